FILE: hdl/upc_pkg.sv
// Shared types, character constants and helper functions for the URL percent codec.
// Used by the front end, the command queue, the back end and the top level.
package upc_pkg;

    // Characters the codec treats specially
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CASE_FOLD  = 8'h20;
    localparam logic [7:0] DIGIT_BIAS = 8'd87;   // 'a' - 10
    localparam logic [3:0] NIBBLE_MAX = 4'd15;

    // Mode register values
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Work passed from front to back
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,   // one byte result
        CMD_ESC   = 2'd1,   // '%' plus two hex digits
        CMD_CLOSE = 2'd2    // empty closing result
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    // Beat index inside an escape triple
    typedef enum logic [1:0] {
        BEAT_PCT = 2'd0,
        BEAT_HI  = 2'd1,
        BEAT_LO  = 2'd2
    } beat_t;

    // Letters, digits and - _ . ~ pass unchanged when encoding
    function automatic logic is_plain(input logic [7:0] c);
        logic digit;
        logic upper;
        logic lower;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
        lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
        return digit || upper || lower || (c == CH_DASH) || (c == CH_UNDER) ||
               (c == CH_DOT) || (c == CH_TILDE);
    endfunction

    // Hex digit value, letters case-folded, wraps for non-hex bytes
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] folded;
        folded = c;
        if ((c >= CH_UP_A) && (c <= CH_UP_Z))
            folded = c + CASE_FOLD;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
            return c - CH_ZERO;
        return folded - DIGIT_BIAS;
    endfunction

    // Lower-case hex character for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n <= 4'd9)
            return CH_ZERO + {4'b0000, n};
        return DIGIT_BIAS + {4'b0000, n};
    endfunction

endpackage

FILE: hdl/url_percent_codec.sv
// URL percent encoder/decoder. Items pass through the command queue to the output
// register, which loads when empty or popped. Throughput: one item per cycle while each
// gives one result and the output is popped; an encoded escape gives three beats, one a
// cycle. A CMD_DEPTH-entry command queue decouples input and output stalls. Reset (rst_n,
// async, active low) selects encode mode, clears decode state and empties the queue and
// output register. Depends on upc_pkg, upc_front, upc_cmdq, upc_back.
module url_percent_codec #(
    parameter int CMD_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode_we,
    input  logic       mode_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       run_last,
    output logic       string_done
);
    import upc_pkg::*;

    logic q_push, q_full, q_valid, q_pop;
    cmd_t q_wcmd, q_rcmd;

    assign full = q_full;

    // Input side: classification and decode state
    upc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .push       (push),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_wcmd)
    );

    // Decoupling queue
    upc_cmdq #(
        .DEPTH (CMD_DEPTH)
    ) u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_cmd   (q_wcmd),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_rcmd)
    );

    // Output side: beat expansion
    upc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd         (q_rcmd),
        .cmd_pop     (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

FILE: hdl/upc_front.sv
// Front end of the URL percent codec: takes input beats, holds mode and decode state, and
// turns each result-giving or final beat into one queue command. Depends on upc_pkg.
module upc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            mode_we,
    input  logic            mode_wdata,
    input  logic            push,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            q_full,
    output logic            q_push,
    output upc_pkg::cmd_t   q_cmd
);
    import upc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HELD = 3'b100
    } phase_t;

    logic       mode_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    logic       produce;
    cmd_op_t    op;
    logic [7:0] data;
    logic [7:0] dval;

    assign accept = push && !q_full;
    assign dval   = digit_value(in_byte);

    // Classify the beat and work out the next decode state
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        produce    = 1'b0;
        op         = CMD_BYTE;
        data       = in_byte;
        if (mode_reg == MODE_ENCODE)
        begin
            phase_next = PH_IDLE;
            held_next  = '0;
            produce    = 1'b1;
            if (is_plain(in_byte))
                op = CMD_BYTE;
            else if (in_byte == CH_SPACE)
                data = CH_PLUS;
            else
                op = CMD_ESC;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_HELD:
                begin
                    phase_next = PH_IDLE;
                    produce    = 1'b1;
                    data       = {held_reg[3:0], 4'b0000} | dval;
                end
                PH_PCT, PH_IDLE:
                begin
                    if ((phase_reg == PH_PCT) && !in_last)
                    begin
                        held_next  = dval;
                        phase_next = PH_HELD;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        if (in_byte == CH_PERCENT)
                        begin
                            if (!in_last)
                                phase_next = PH_PCT;
                        end
                        else
                        begin
                            produce = 1'b1;
                            if (in_byte == CH_PLUS)
                                data = CH_SPACE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        // Final beat always closes the string
        if (in_last)
        begin
            phase_next = PH_IDLE;
            held_next  = '0;
            if (!produce)
            begin
                op   = CMD_CLOSE;
                data = '0;
            end
        end
    end

    assign q_push     = accept && (produce || in_last);
    assign q_cmd.op   = op;
    assign q_cmd.data = data;
    assign q_cmd.last = in_last;

    // Mode register and decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENCODE;
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            if (mode_we)
                mode_reg <= mode_wdata;
            if (accept)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A final beat always leaves a command behind
    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |-> q_push)
        else $error("final beat produced no command");

    // Decode state is idle after the final beat of a string
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> phase_reg == PH_IDLE)
        else $error("decode state not idle after string end");

    // Encode mode never leaves a pending escape
    a_encode_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_ENCODE |=> phase_reg == PH_IDLE)
        else $error("pending escape after encode beat");
`endif

endmodule

FILE: hdl/upc_cmdq.sv
// Short command queue between the front and back ends of the URL percent codec.
// Depends on upc_pkg for the command type.
module upc_cmdq #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  upc_pkg::cmd_t   wr_cmd,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output upc_pkg::cmd_t   rd_cmd
);
    import upc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wptr_reg] <= wr_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    // Fill count never goes past the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count overflow");

    // A write with no read grows the count by one
    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow");

    // Equal pointers mean empty or full
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        wptr_reg == rptr_reg |-> count_reg == '0 || count_reg == FULL_CNT)
        else $error("queue pointers inconsistent with count");
`endif

endmodule

FILE: hdl/upc_back.sv
// Back end of the URL percent codec: expands queued commands into result beats
// and holds them in an output register. Depends on upc_pkg.
module upc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  upc_pkg::cmd_t   cmd,
    output logic            cmd_pop,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            run_last,
    output logic            string_done
);
    import upc_pkg::*;

    beat_t      beat_reg;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       has_reg, rlast_reg, done_reg;
    logic       advance;
    logic       final_beat;
    logic [7:0] beat_byte;
    logic       beat_has;

    assign advance = cmd_valid && (!out_valid_reg || pop);

    // Fields of the current beat
    always_comb
    begin
        beat_byte  = cmd.data;
        beat_has   = 1'b1;
        final_beat = 1'b1;
        unique case (cmd.op)
            CMD_ESC:
            begin
                final_beat = (beat_reg == BEAT_LO);
                case (beat_reg)
                    BEAT_PCT: beat_byte = CH_PERCENT;
                    BEAT_HI:  beat_byte = hex_char(cmd.data[7:4]);
                    default:  beat_byte = hex_char(cmd.data[3:0] & NIBBLE_MAX);
                endcase
            end
            CMD_CLOSE:
            begin
                beat_byte = '0;
                beat_has  = 1'b0;
            end
            default:
            begin
                beat_byte = cmd.data;
            end
        endcase
    end

    assign cmd_pop = advance && final_beat;

    // Beat counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= BEAT_PCT;
        else if (advance)
        begin
            if (final_beat)
                beat_reg <= BEAT_PCT;
            else if (beat_reg == BEAT_PCT)
                beat_reg <= BEAT_HI;
            else
                beat_reg <= BEAT_LO;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg  <= beat_byte;
            has_reg   <= beat_has;
            rlast_reg <= final_beat;
            done_reg  <= final_beat && cmd.last;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = byte_reg;
    assign has_byte    = has_reg;
    assign run_last    = rlast_reg;
    assign string_done = done_reg;

`ifndef NO_ASSERTIONS
    // Mid-escape the command must still be at the queue head
    a_beat_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg != BEAT_PCT |-> cmd_valid && cmd.op == CMD_ESC)
        else $error("escape beat without escape command");

    // The end of a string is always the end of its item's run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> rlast_reg)
        else $error("string end without run end");

    // Empty closing results only close strings
    a_close_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !has_reg |-> done_reg)
        else $error("empty result that does not end the string");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for url_percent_codec: encode and decode strings, random stalls.
// Depends on upc_pkg (character constants, mode values) and the url_percent_codec RTL.
`timescale 1ns / 1ps

module testbench;
    import upc_pkg::*;

    // One input beat and one expected output beat
    typedef struct {
        logic [7:0] data;
        logic       last;
    } str_byte_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_done;
    } codec_beat_t;

    typedef enum logic [2:0] {
        ESC_IDLE  = 3'b001,
        ESC_PCT   = 3'b010,
        ESC_DIGIT = 3'b100
    } esc_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       mode_we = 1'b0;
    logic       mode_wdata = 1'b0;
    logic       push = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_done;

    str_byte_t   pending_bytes[$];
    codec_beat_t expected_beats[$];

    // Shadow of the codec's mode and escape state
    logic       shadow_mode = MODE_ENCODE;
    esc_state_t shadow_esc = ESC_IDLE;
    logic [7:0] shadow_held = 8'h00;

    int  fail_cnt = 0;
    bit  push_taken = 1'b0;
    bit  calm = 1'b0;
    int  push_gap_pct = 25;
    int  pop_gap_pct = 25;
    int  push_gap_cnt = 0;
    int  pop_gap_cnt = 0;
    string hex_digits = "0123456789abcdef";

    url_percent_codec u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode_we     (mode_we),
        .mode_wdata  (mode_wdata),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

    always #5 clk = ~clk;

    // Hex digit value with case folding; non-hex bytes wrap mod 256
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] lc;
        if (c >= CH_ZERO && c <= CH_NINE)
            return c - CH_ZERO;
        lc = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_FOLD) : c;
        return lc - CH_LO_A + 8'd10;
    endfunction

    // Compute the beats one accepted byte produces and queue them
    task automatic predict_codec(input logic [7:0] b, input logic last);
        logic [7:0] res[3];
        int         n;
        logic       plain;
        codec_beat_t beat;
        n = 0;
        plain = (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_UP_A && b <= CH_UP_Z) ||
                (b >= CH_LO_A && b <= CH_LO_Z) || b == CH_DASH || b == CH_UNDER ||
                b == CH_DOT || b == CH_TILDE;
        if (shadow_mode == MODE_ENCODE) begin
            shadow_esc = ESC_IDLE;
            shadow_held = 8'h00;
            if (plain) begin
                res[n++] = b;
            end
            else if (b == CH_SPACE) begin
                res[n++] = CH_PLUS;
            end
            else begin
                res[n++] = CH_PERCENT;
                res[n++] = hex_digits[b[7:4]];
                res[n++] = hex_digits[b[3:0]];
            end
        end
        else if (shadow_esc == ESC_DIGIT) begin
            res[n++] = (shadow_held << 4) | hex_value(b);
            shadow_esc = ESC_IDLE;
        end
        else if (shadow_esc == ESC_PCT && !last) begin
            shadow_held = hex_value(b);
            shadow_esc = ESC_DIGIT;
        end
        else begin
            shadow_esc = ESC_IDLE;
            if (b == CH_PERCENT) begin
                if (!last)
                    shadow_esc = ESC_PCT;
            end
            else if (b == CH_PLUS) begin
                res[n++] = CH_SPACE;
            end
            else begin
                res[n++] = b;
            end
        end
        if (last) begin
            shadow_esc = ESC_IDLE;
            shadow_held = 8'h00;
        end
        // empty close when the final byte yields nothing
        if (n == 0 && last) begin
            beat = '{8'h00, 1'b0, 1'b1, 1'b1};
            expected_beats.push_back(beat);
        end
        for (int i = 0; i < n; i++) begin
            beat.out_byte = res[i];
            beat.has_byte = 1'b1;
            beat.run_last = (i == n - 1);
            beat.string_done = (i == n - 1) && last;
            expected_beats.push_back(beat);
        end
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    // Monitor: check popped beats, predict accepted ones
    always @(posedge clk) begin
        codec_beat_t want;
        if (rst_n) begin
            if (mode_we)
                shadow_mode = mode_wdata;
            if (pop && !empty) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual byte %0h",
                             $time, out_byte);
                    fail_cnt++;
                end
                else begin
                    want = expected_beats.pop_front();
                    check_field("out_byte", want.out_byte, out_byte);
                    check_field("has_byte", want.has_byte, has_byte);
                    check_field("run_last", want.run_last, run_last);
                    check_field("string_done", want.string_done, string_done);
                end
            end
            push_taken = push && !full;
            if (push_taken)
                predict_codec(in_byte, in_last);
        end
    end

    // Input driver: holds a beat until taken, random gap bursts between beats
    always @(negedge clk) begin
        logic next_push;
        next_push = 1'b0;
        if (rst_n) begin
            if (push && push_taken)
                void'(pending_bytes.pop_front());
            if (push && !push_taken) begin
                next_push = 1'b1;
            end
            else if (push_gap_cnt > 0) begin
                push_gap_cnt--;
            end
            else if (!calm && pending_bytes.size() > 0 &&
                     $urandom_range(0, 99) < push_gap_pct) begin
                push_gap_cnt = $urandom_range(1, 7) - 1;
            end
            else if (pending_bytes.size() > 0) begin
                next_push = 1'b1;
            end
        end
        push <= next_push;
        if (next_push) begin
            in_byte <= pending_bytes[0].data;
            in_last <= pending_bytes[0].last;
        end
    end

    // Output side: random stall bursts on pop
    always @(negedge clk) begin
        logic next_pop;
        next_pop = 1'b0;
        if (rst_n) begin
            if (pop_gap_cnt > 0) begin
                pop_gap_cnt--;
            end
            else if (!calm && $urandom_range(0, 99) < pop_gap_pct) begin
                pop_gap_cnt = $urandom_range(1, 7) - 1;
            end
            else begin
                next_pop = 1'b1;
            end
        end
        pop <= next_pop;
    end

    task automatic add_byte(input logic [7:0] b, input logic last);
        str_byte_t item;
        item.data = b;
        item.last = last;
        pending_bytes.push_back(item);
    endtask

    task automatic add_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Wait until all beats are in and out, then let the pipeline drain
    task automatic settle_codec();
        do begin
            @(posedge clk);
            #1;
        end while (pending_bytes.size() != 0 || push || expected_beats.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        settle_codec();
        @(negedge clk);
        mode_we <= 1'b1;
        mode_wdata <= m;
        @(negedge clk);
        mode_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_hex_char();
        string set;
        set = "0123456789abcdefABCDEF";
        return set[$urandom_range(0, 21)];
    endfunction

    // One random string; escapes in decode strings mostly have well-formed hex digits
    task automatic add_random_string(input logic decode_style, inout int count);
        logic [7:0] buf_q[$];
        int         len;
        int         r;
        string      plain_set;
        plain_set = "-_.~ azAZ09";
        len = $urandom_range(1, 12);
        while (buf_q.size() < len) begin
            r = $urandom_range(0, 9);
            if (!decode_style) begin
                if (r < 5)
                    buf_q.push_back(8'($urandom_range(1, 255)));
                else
                    buf_q.push_back(plain_set[$urandom_range(0, 10)]);
            end
            else if (r < 4) begin
                buf_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            else if (r == 4) begin
                buf_q.push_back(CH_PLUS);
            end
            else if (r < 8) begin
                buf_q.push_back(CH_PERCENT);
                buf_q.push_back($urandom_range(0, 7) == 0 ? 8'($urandom_range(1, 255))
                                                          : pick_hex_char());
                buf_q.push_back($urandom_range(0, 7) == 0 ? 8'($urandom_range(1, 255))
                                                          : pick_hex_char());
            end
            else if (r == 8) begin
                buf_q.push_back(8'($urandom_range(1, 255)));
            end
            else begin
                buf_q.push_back(CH_PERCENT);
            end
        end
        // cut at the drawn length; may leave a short escape at the end
        for (int i = 0; i < len; i++)
            add_byte(buf_q[i], i == len - 1);
        count += len;
    endtask

    initial begin
        logic modes[6];
        int   push_pcts[6];
        int   pop_pcts[6];
        int   count;
        modes = '{MODE_DECODE, MODE_ENCODE, MODE_DECODE, MODE_DECODE, MODE_ENCODE,
                  MODE_DECODE};
        push_pcts = '{25, 50, 0, 30, 10, 0};
        pop_pcts = '{25, 0, 50, 30, 40, 0};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // encode: unreserved set, space, byte extremes
        add_text("aZ9-_.~ ", 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'hFF, 1'b1);
        write_mode(MODE_DECODE);
        // decode: plus, hex escape, non-hex digits
        add_text("+%4a%zZ", 1'b1);
        // short escape before a final plus
        add_text("a%+", 1'b1);
        // lone final percent, and percent as final byte: empty close
        add_text("%", 1'b1);
        add_text("x%", 1'b1);
        // pending escape dropped by switching to encode mid-string
        add_text("%", 1'b0);
        write_mode(MODE_ENCODE);
        add_text("q", 1'b1);

        for (int p = 0; p < 6; p++) begin
            write_mode(modes[p]);
            if (p == 5)
                calm = 1'b1;
            push_gap_pct = push_pcts[p];
            pop_gap_pct = pop_pcts[p];
            count = 0;
            while (count < 44)
                add_random_string(modes[p] == MODE_DECODE, count);
        end

        settle_codec();
        repeat (12) @(posedge clk);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
